// ----- design/tfp_pkg.sv -----
// Shared types and constants for the touch frame parser.
// Used by tfp_front, tfp_job_queue, tfp_back, the top level and its checker.
package tfp_pkg;

   localparam logic [7:0] FRAME_LEAD       = 8'h55;  // 'U'
   localparam logic [7:0] FRAME_TYPE_TOUCH = 8'h54;  // 'T'
   localparam logic [7:0] CODE_PRESS       = 8'd1;
   localparam logic [7:0] CODE_RELEASE     = 8'd4;
   localparam logic [3:0] FRAME_LAST_COUNT = 4'd9;   // count before the tenth byte
   localparam logic [3:0] FRAME_STORE_LAST = 4'd6;   // bytes 1..6 are kept

   localparam logic signed [15:0] OFFSCREEN_POS = 16'sd4000;
   localparam logic signed [15:0] POS_MAX       = 16'sh7fff;
   localparam logic signed [15:0] POS_MIN       = 16'sh8000;

   localparam int CFG_W   = 12;
   localparam int MAG_W   = 29;                 // |size * (raw - start)| fits here
   localparam logic [4:0] DIV_LAST_STEP = 5'(MAG_W - 1);

   localparam logic [CFG_W-1:0] RST_CAL_X_START   = 12'd3670;
   localparam logic [CFG_W-1:0] RST_CAL_X_END     = 12'd400;
   localparam logic [CFG_W-1:0] RST_CAL_Y_START   = 12'd500;
   localparam logic [CFG_W-1:0] RST_CAL_Y_END     = 12'd3540;
   localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 12'd800;
   localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 12'd600;

   typedef enum logic [2:0] {
      CSR_CAL_X_START   = 3'd0,
      CSR_CAL_X_END     = 3'd1,
      CSR_CAL_Y_START   = 3'd2,
      CSR_CAL_Y_END     = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_MOVE    = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_PREP,
      BK_DIV,
      BK_SAT,
      BK_EMIT0,
      BK_EMIT1
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] cal_x_start;
      logic [CFG_W-1:0] cal_x_end;
      logic [CFG_W-1:0] cal_y_start;
      logic [CFG_W-1:0] cal_y_end;
      logic [CFG_W-1:0] screen_width;
      logic [CFG_W-1:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic        is_release;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
   } job_type;

   typedef struct packed {
      event_kind_type     kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               button_down;
      logic               last_of_run;
   } result_type;

endpackage

// ----- design/touch_frame_parser.sv -----
// Touch frame parser: takes one received byte per cycle whenever req_full is
// low. Bytes are dropped until a 'U' lead byte; the next nine bytes close the
// frame. A touch frame with code 1 yields one press result, code 4 a release
// and then an offscreen move to (4000,4000). For each completed frame the back end
// takes the job, then per axis multiplies, prepares, runs 29 steps of the
// one-bit-per-cycle divider and saturates, then emits each result (an axis
// with a zero calibration span skips the divider), so the divider sets the
// rate; a two-job queue lets bytes of the following frames keep arriving
// meanwhile. The user must write calibration registers through csr_* only
// while the block is idle; the block itself does not enforce this. No
// clearing pass after reset. Uses tfp_pkg, tfp_front, tfp_job_queue and
// tfp_back.
module touch_frame_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_event_kind,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic               rsp_button_down,
   output logic               rsp_last_of_run,
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   tfp_pkg::cfg_type    cfg_ff, cfg_in;
   tfp_pkg::job_type    front_job;
   tfp_pkg::job_type    queue_head;
   tfp_pkg::result_type head;
   logic                byte_valid;
   logic                front_push;
   logic                queue_valid;
   logic                queue_pop;

   assign byte_valid = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            tfp_pkg::CSR_CAL_X_START:   cfg_in.cal_x_start   = csr_wdata;
            tfp_pkg::CSR_CAL_X_END:     cfg_in.cal_x_end     = csr_wdata;
            tfp_pkg::CSR_CAL_Y_START:   cfg_in.cal_y_start   = csr_wdata;
            tfp_pkg::CSR_CAL_Y_END:     cfg_in.cal_y_end     = csr_wdata;
            tfp_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            tfp_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_x_start   <= tfp_pkg::RST_CAL_X_START;
         cfg_ff.cal_x_end     <= tfp_pkg::RST_CAL_X_END;
         cfg_ff.cal_y_start   <= tfp_pkg::RST_CAL_Y_START;
         cfg_ff.cal_y_end     <= tfp_pkg::RST_CAL_Y_END;
         cfg_ff.screen_width  <= tfp_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= tfp_pkg::RST_SCREEN_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .job_push   (front_push),
      .job        (front_job)
   );

   tfp_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .head     (queue_head)
   );

   tfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (queue_valid),
      .job       (queue_head),
      .job_pop   (queue_pop),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_head  (head)
   );

   assign rsp_event_kind  = head.kind;
   assign rsp_pos_x       = head.pos_x;
   assign rsp_pos_y       = head.pos_y;
   assign rsp_button_down = head.button_down;
   assign rsp_last_of_run = head.last_of_run;

endmodule

// ----- design/tfp_front.sv -----
// Byte-level front end: hunts for the lead byte, gathers a 10-byte frame
// and hands touch frames with a known code on as jobs. Uses tfp_pkg.
module tfp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output logic             job_push,
   output tfp_pkg::job_type job
);

   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] frame_ff [6];
   logic [2:0] wr_idx;
   logic       store;
   logic       frame_done;
   logic       known_code;

   assign wr_idx     = byte_count_ff[2:0] - 3'd1;
   assign store      = byte_valid && (byte_count_ff != 4'd0)
                       && (byte_count_ff <= tfp_pkg::FRAME_STORE_LAST);
   assign frame_done = byte_valid && (byte_count_ff == tfp_pkg::FRAME_LAST_COUNT);

   assign known_code = (frame_ff[1] == tfp_pkg::CODE_PRESS)
                       || (frame_ff[1] == tfp_pkg::CODE_RELEASE);
   assign job_push   = frame_done && (frame_ff[0] == tfp_pkg::FRAME_TYPE_TOUCH)
                       && known_code;

   assign job.is_release = (frame_ff[1] == tfp_pkg::CODE_RELEASE);
   assign job.raw_x      = {frame_ff[3], frame_ff[2]};
   assign job.raw_y      = {frame_ff[5], frame_ff[4]};

   always_comb begin
      byte_count_in = byte_count_ff;
      if (byte_valid) begin
         if (byte_count_ff == 4'd0) begin
            if (rx_byte == tfp_pkg::FRAME_LEAD) begin
               byte_count_in = 4'd1;
            end
         end else if (frame_done) begin
            byte_count_in = 4'd0;
         end else begin
            byte_count_in = byte_count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         frame_ff[wr_idx] <= rx_byte;
      end
   end

endmodule

// ----- design/tfp_job_queue.sv -----
// Two-entry queue of decoded touch jobs between front and back end.
// Uses tfp_pkg for the job type.
module tfp_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output tfp_pkg::job_type head
);

   tfp_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/tfp_back.sv -----
// Back end: scales both axes of a job with one multiplier and a bit-serial
// divider, then queues the press/release/move results. Uses tfp_pkg.
module tfp_back (
   input  logic                clock,
   input  logic                reset,
   input  tfp_pkg::cfg_type    cfg,
   input  logic                job_valid,
   input  tfp_pkg::job_type    job,
   output logic                job_pop,
   output logic                out_empty,
   input  logic                out_pop,
   output tfp_pkg::result_type out_head
);

   tfp_pkg::back_state_type state_ff, state_in;
   tfp_pkg::job_type        job_ff, job_in;
   logic                    axis_ff, axis_in;       // 0 x, 1 y
   logic signed [29:0]      prod_ff, prod_in;
   logic signed [12:0]      span_ff, span_in;
   logic [tfp_pkg::MAG_W-1:0] mag_ff, mag_in;        // dividend, then quotient
   logic [11:0]             rem_ff, rem_in;
   logic [11:0]             div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic [4:0]              step_ff, step_in;
   logic signed [15:0]      sx_ff, sx_in;
   logic signed [15:0]      sy_ff, sy_in;

   // result queue
   tfp_pkg::result_type     res_ff [2];
   logic                    res_wr_ff, res_rd_ff;
   logic [1:0]              res_cnt_ff, res_cnt_in;
   logic                    res_full;
   logic                    res_push;
   logic                    res_pop;
   tfp_pkg::result_type     res_new;

   // axis operands
   logic [15:0]             raw;
   logic [11:0]             start, stop, size;
   logic signed [16:0]      diff;
   logic signed [29:0]      prod;
   logic signed [12:0]      span;
   logic [29:0]             prod_neg;
   logic [12:0]             span_neg;
   logic [12:0]             rshift;
   logic [12:0]             rsub;
   logic                    ge;
   logic [tfp_pkg::MAG_W-1:0] q_neg;
   logic signed [15:0]      sat;

   assign raw   = axis_ff ? job_ff.raw_y : job_ff.raw_x;
   assign start = axis_ff ? cfg.cal_y_start : cfg.cal_x_start;
   assign stop  = axis_ff ? cfg.cal_y_end : cfg.cal_x_end;
   assign size  = axis_ff ? cfg.screen_height : cfg.screen_width;

   assign diff = {raw[15], raw} - {5'd0, start};
   assign prod = diff * $signed({1'b0, size});
   assign span = {1'b0, stop} - {1'b0, start};

   assign prod_neg = -prod_ff;
   assign span_neg = -span_ff;

   assign rshift = {rem_ff, mag_ff[tfp_pkg::MAG_W-1]};
   assign rsub   = rshift - {1'b0, div_ff};
   assign ge     = (rshift >= {1'b0, div_ff});

   assign q_neg = -mag_ff;

   always_comb begin
      if (neg_ff) begin
         sat = (mag_ff > tfp_pkg::MAG_W'(32768)) ? tfp_pkg::POS_MIN : q_neg[15:0];
      end else begin
         sat = (mag_ff > tfp_pkg::MAG_W'(32767)) ? tfp_pkg::POS_MAX : mag_ff[15:0];
      end
   end

   assign res_full  = (res_cnt_ff == 2'd2);
   assign out_empty = (res_cnt_ff == 2'd0);
   assign out_head  = res_ff[res_rd_ff];
   assign res_pop   = out_pop && !out_empty;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      axis_in  = axis_ff;
      prod_in  = prod_ff;
      span_in  = span_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      job_pop  = 1'b0;
      res_push = 1'b0;
      res_new.kind        = tfp_pkg::EV_PRESS;
      res_new.pos_x       = sx_ff;
      res_new.pos_y       = sy_ff;
      res_new.button_down = 1'b1;
      res_new.last_of_run = 1'b1;

      case (state_ff)
         tfp_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               axis_in  = 1'b0;
               state_in = tfp_pkg::BK_MUL;
            end
         end
         tfp_pkg::BK_MUL: begin
            prod_in  = prod;
            span_in  = span;
            state_in = tfp_pkg::BK_PREP;
         end
         tfp_pkg::BK_PREP: begin
            // truncation toward zero: divide magnitudes, sign applied after
            neg_in  = prod_ff[29] ^ span_ff[12];
            mag_in  = prod_ff[29] ? prod_neg[tfp_pkg::MAG_W-1:0]
                                  : prod_ff[tfp_pkg::MAG_W-1:0];
            div_in  = span_ff[12] ? span_neg[11:0] : span_ff[11:0];
            rem_in  = 12'd0;
            step_in = 5'd0;
            if (span_ff == 13'sd0) begin
               mag_in   = '0;
               state_in = tfp_pkg::BK_SAT;
            end else begin
               state_in = tfp_pkg::BK_DIV;
            end
         end
         tfp_pkg::BK_DIV: begin
            rem_in  = ge ? rsub[11:0] : rshift[11:0];
            mag_in  = {mag_ff[tfp_pkg::MAG_W-2:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == tfp_pkg::DIV_LAST_STEP) begin
               state_in = tfp_pkg::BK_SAT;
            end
         end
         tfp_pkg::BK_SAT: begin
            if (axis_ff) begin
               sy_in    = sat;
               state_in = tfp_pkg::BK_EMIT0;
            end else begin
               sx_in    = sat;
               axis_in  = 1'b1;
               state_in = tfp_pkg::BK_MUL;
            end
         end
         tfp_pkg::BK_EMIT0: begin
            res_new.kind        = job_ff.is_release ? tfp_pkg::EV_RELEASE
                                                    : tfp_pkg::EV_PRESS;
            res_new.last_of_run = !job_ff.is_release;
            if (!res_full) begin
               res_push = 1'b1;
               state_in = job_ff.is_release ? tfp_pkg::BK_EMIT1 : tfp_pkg::BK_IDLE;
            end
         end
         tfp_pkg::BK_EMIT1: begin
            res_new.kind        = tfp_pkg::EV_MOVE;
            res_new.pos_x       = tfp_pkg::OFFSCREEN_POS;
            res_new.pos_y       = tfp_pkg::OFFSCREEN_POS;
            res_new.button_down = 1'b0;
            if (!res_full) begin
               res_push = 1'b1;
               state_in = tfp_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = tfp_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (res_push && !res_pop) begin
         res_cnt_in = res_cnt_ff + 2'd1;
      end else if (res_pop && !res_push) begin
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tfp_pkg::BK_IDLE;
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         res_wr_ff  <= res_push ? ~res_wr_ff : res_wr_ff;
         res_rd_ff  <= res_pop ? ~res_rd_ff : res_rd_ff;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in;
      span_ff <= span_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      if (res_push) begin
         res_ff[res_wr_ff] <= res_new;
      end
   end

endmodule

// ----- design/tfp_checker.sv -----
// Port-level checks for touch_frame_parser, bound to the top level.
// Uses tfp_pkg for the event codes.
module tfp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [1:0]         rsp_event_kind,
   input logic signed [15:0] rsp_pos_x,
   input logic signed [15:0] rsp_pos_y,
   input logic               rsp_button_down,
   input logic               rsp_last_of_run
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_event_kind)
         && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_button_down) && $stable(rsp_last_of_run)))
      else $error("waiting item changed before it was taken");

   a_move_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == tfp_pkg::EV_MOVE) |->
         (!rsp_button_down && rsp_last_of_run
          && rsp_pos_x == tfp_pkg::OFFSCREEN_POS && rsp_pos_y == tfp_pkg::OFFSCREEN_POS))
      else $error("offscreen move item malformed");

   a_press_release_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_event_kind == tfp_pkg::EV_PRESS
                      || rsp_event_kind == tfp_pkg::EV_RELEASE)) |->
         (rsp_button_down && (rsp_last_of_run == (rsp_event_kind == tfp_pkg::EV_PRESS))))
      else $error("press or release item malformed");

   a_release_then_move: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_event_kind == tfp_pkg::EV_RELEASE) |=>
         (rsp_empty || rsp_event_kind == tfp_pkg::EV_MOVE))
      else $error("release not followed by offscreen move");

endmodule

bind touch_frame_parser tfp_checker u_tfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_button_down (rsp_button_down),
   .rsp_last_of_run (rsp_last_of_run)
);
